>>> design/rmm_pkg.sv
// ============================================================================
// rmm_pkg
// Shared types and constants of the ramped matrix mixer.
// ============================================================================
`default_nettype none

package rmm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 20;
  localparam int CGAIN_BITS  = 32;
  localparam int RAMP_BITS   = 16;
  localparam int ACC_BITS    = 48;
  localparam int DIV_W       = 34;
  localparam int PROD_BITS   = SAMPLE_BITS + CGAIN_BITS;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_SET    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] CFG_NUM_INPUTS  = 2'd0;
  localparam logic [1:0] CFG_NUM_OUTPUTS = 2'd1;
  localparam logic [1:0] CFG_RAMP        = 2'd2;

  typedef struct packed {
    logic [1:0]                    func;
    logic [2:0]                    in_channel;
    logic [2:0]                    out_channel;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic signed [GAIN_BITS-1:0]   gain_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                    out_channel_id;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic signed [GAIN_BITS-1:0]  target;
    logic signed [CGAIN_BITS-1:0] current;
    logic signed [CGAIN_BITS-1:0] step;
    logic [RAMP_BITS-1:0]         remaining;
  } cell_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [RAMP_BITS-1:0]    divisor;
  } rmm_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [CGAIN_BITS-1:0] quotient;
  } rmm_div_rsp_t;

endpackage

`default_nettype wire

>>> design/rmm_div.sv
// ============================================================================
// rmm_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ============================================================================
`default_nettype none

module rmm_div import rmm_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  rmm_div_req_t req,
  output rmm_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic                 busy;
  logic                 done;
  logic                 neg;
  logic [CNT_W-1:0]     count;
  logic [RAMP_BITS-1:0] rem;
  logic [DIV_W-1:0]     quo;
  logic [RAMP_BITS:0]   trial;
  logic                 fits;
  logic [DIV_W-1:0]     quo_signed;

  assign trial      = {rem, quo[DIV_W-1]};
  assign fits       = trial >= {1'b0, req.divisor};
  assign quo_signed = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
        rem   <= '0;
        neg   <= req.dividend[DIV_W-1];
        quo   <= req.dividend[DIV_W-1] ? (~req.dividend + 1'b1) : req.dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= RAMP_BITS'(trial - {1'b0, req.divisor});
        end else begin
          rem <= trial[RAMP_BITS-1:0];
        end
        quo   <= {quo[DIV_W-2:0], fits};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo_signed[CGAIN_BITS-1:0];

endmodule

`default_nettype wire

>>> design/ramped_matrix_mixer.sv
// ============================================================================
// ramped_matrix_mixer
// Matrix mixer with per-cell linear gain ramps, cells and sums in memories.
// ============================================================================
//  channel  direction  payload     accepted when
//  in       input      in_item_t   in_valid & in_ready
//  out      output     out_item_t  out_valid & out_ready
//  cfg      input      index,data  cfg_valid & cfg_ready (always ready)
//
// After reset a clearing pass over every cell address zeroes both memories; no
// item is taken during it. A sample item steps through cell read, update and
// multiply, and accumulate for each output in use; a frame close then reads out
// and clears each of the MAX_OUTPUTS sums, and holds while the output stalls.
// A set-gain item that starts a ramp waits for the serial divider; a clear item
// repeats that sweep over every cell.
`default_nettype none

module ramped_matrix_mixer import rmm_pkg::*; #(
  parameter int MAX_INPUTS  = 8,
  parameter int MAX_OUTPUTS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data,
  input  wire logic  cfg_valid,
  output logic       cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int NCELLS = MAX_INPUTS * MAX_OUTPUTS;
  localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int OW     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  typedef enum logic [9:0] {
    S_INIT    = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_MIX_RD  = 10'b0000000100,
    S_MIX_UPD = 10'b0000001000,
    S_MIX_ACC = 10'b0000010000,
    S_EMIT_RD = 10'b0000100000,
    S_EMIT_WR = 10'b0001000000,
    S_SET_RD  = 10'b0010000000,
    S_SET_CHK = 10'b0100000000,
    S_SET_DIV = 10'b1000000000
  } state_t;

  state_t state;

  logic [3:0]           num_inputs;
  logic [3:0]           num_outputs;
  logic [RAMP_BITS-1:0] ramp_samples;
  logic [3:0]           nin;
  logic [3:0]           nout;

  logic [CW-1:0]                 cell_addr;
  logic [OW-1:0]                 o_idx;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [GAIN_BITS-1:0]   set_gain;
  logic                          is_clear;
  logic                          frame_close;
  logic signed [PROD_BITS-1:0]   prod;

  cell_t         cell_mem [NCELLS];
  cell_t         cell_rdata;
  cell_t         cell_wdata;
  logic          cell_we;
  logic [ACC_BITS-1:0] acc_mem [MAX_OUTPUTS];
  logic [ACC_BITS-1:0] acc_rdata;
  logic [ACC_BITS-1:0] acc_wdata;
  logic [OW-1:0]       acc_waddr;
  logic                acc_we;

  rmm_div_req_t div_req;
  rmm_div_rsp_t div_rsp;

  logic signed [CGAIN_BITS-1:0] mix_gain;
  cell_t                        mix_cell;
  logic signed [CGAIN_BITS-1:0] set_gain32;
  logic                         emit_go;
  logic                         emit_used;
  logic signed [SAMPLE_BITS-1:0] sat_sample;
  logic                         set_last;

  assign nin  = (num_inputs == 4'd0) ? 4'd1 :
                (int'(num_inputs) > MAX_INPUTS) ? 4'(MAX_INPUTS) : num_inputs;
  assign nout = (num_outputs == 4'd0) ? 4'd1 :
                (int'(num_outputs) > MAX_OUTPUTS) ? 4'(MAX_OUTPUTS) : num_outputs;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign set_gain32 = {{(CGAIN_BITS-GAIN_BITS-8){set_gain[GAIN_BITS-1]}}, set_gain, 8'd0};
  assign emit_used  = int'(o_idx) < int'(nout);
  assign emit_go    = !emit_used || !out_valid || out_ready;
  assign set_last   = !is_clear || (cell_addr == CW'(NCELLS - 1));

  // A cell that is still ramping plays its current gain, then steps it.
  always_comb begin
    mix_cell = cell_rdata;
    if (cell_rdata.remaining != '0) begin
      mix_gain           = cell_rdata.current;
      mix_cell.current   = cell_rdata.current + cell_rdata.step;
      mix_cell.remaining = cell_rdata.remaining - 1'b1;
    end else begin
      mix_gain         = {{(CGAIN_BITS-GAIN_BITS-8){cell_rdata.target[GAIN_BITS-1]}},
                          cell_rdata.target, 8'd0};
      mix_cell.current = mix_gain;
    end
  end

  always_comb begin
    if (acc_rdata[ACC_BITS-1:SAMPLE_BITS-1] == '0 ||
        acc_rdata[ACC_BITS-1:SAMPLE_BITS-1] == '1) begin
      sat_sample = acc_rdata[SAMPLE_BITS-1:0];
    end else if (acc_rdata[ACC_BITS-1]) begin
      sat_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_comb begin
    cell_we          = 1'b0;
    cell_wdata       = '0;
    acc_we           = 1'b0;
    acc_wdata        = '0;
    acc_waddr        = o_idx;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(set_gain32) - DIV_W'(cell_rdata.current);
    div_req.divisor  = ramp_samples;
    case (state)
      S_INIT: begin
        cell_we   = 1'b1;
        acc_waddr = cell_addr[OW-1:0];
        acc_we    = int'(cell_addr) < MAX_OUTPUTS;
      end
      S_MIX_UPD: begin
        cell_we    = 1'b1;
        cell_wdata = mix_cell;
      end
      S_MIX_ACC: begin
        acc_we    = 1'b1;
        acc_wdata = acc_rdata + {{(ACC_BITS-CGAIN_BITS){prod[PROD_BITS-1]}},
                                 prod[PROD_BITS-1:PROD_BITS-CGAIN_BITS]};
      end
      S_EMIT_WR: begin
        acc_we = emit_go;
      end
      S_SET_CHK: begin
        if (cell_rdata.target != set_gain) begin
          if (ramp_samples == '0) begin
            cell_we            = 1'b1;
            cell_wdata.target  = set_gain;
            cell_wdata.current = set_gain32;
          end else begin
            div_req.start = 1'b1;
          end
        end
      end
      S_SET_DIV: begin
        cell_we              = div_rsp.done;
        cell_wdata.target    = set_gain;
        cell_wdata.current   = cell_rdata.current;
        cell_wdata.step      = div_rsp.quotient;
        cell_wdata.remaining = ramp_samples;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_addr] <= cell_wdata;
    end
    cell_rdata <= cell_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rdata <= acc_mem[o_idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_MIX_UPD) begin
      prod <= sample * mix_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      cell_addr    <= '0;
      o_idx        <= '0;
      out_valid    <= 1'b0;
      num_inputs   <= 4'd1;
      num_outputs  <= 4'd1;
      ramp_samples <= RAMP_BITS'(480);
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_NUM_INPUTS:  num_inputs   <= cfg_data[3:0];
          CFG_NUM_OUTPUTS: num_outputs  <= cfg_data[3:0];
          CFG_RAMP:        ramp_samples <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready &&
          !(state == S_EMIT_WR && emit_go && emit_used)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (cell_addr == CW'(NCELLS - 1)) begin
            cell_addr <= '0;
            state     <= S_IDLE;
          end else begin
            cell_addr <= cell_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            sample      <= in_data.in_sample;
            frame_close <= int'(in_data.in_channel) == int'(nin) - 1;
            case (in_data.func)
              FUNC_SAMPLE: begin
                if (int'(in_data.in_channel) < int'(nin)) begin
                  cell_addr <= CW'(int'(in_data.in_channel) * MAX_OUTPUTS);
                  o_idx     <= '0;
                  state     <= S_MIX_RD;
                end
              end
              FUNC_SET: begin
                if (int'(in_data.in_channel) < int'(nin) &&
                    int'(in_data.out_channel) < int'(nout)) begin
                  cell_addr <= CW'(int'(in_data.in_channel) * MAX_OUTPUTS +
                                   int'(in_data.out_channel));
                  set_gain  <= in_data.gain_value;
                  is_clear  <= 1'b0;
                  state     <= S_SET_RD;
                end
              end
              FUNC_CLEAR: begin
                cell_addr <= '0;
                set_gain  <= '0;
                is_clear  <= 1'b1;
                state     <= S_SET_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_MIX_RD: state <= S_MIX_UPD;
        S_MIX_UPD: state <= S_MIX_ACC;
        S_MIX_ACC: begin
          if (int'(o_idx) == int'(nout) - 1) begin
            o_idx <= '0;
            state <= frame_close ? S_EMIT_RD : S_IDLE;
          end else begin
            o_idx     <= o_idx + 1'b1;
            cell_addr <= cell_addr + 1'b1;
            state     <= S_MIX_RD;
          end
        end
        S_EMIT_RD: state <= S_EMIT_WR;
        S_EMIT_WR: begin
          if (emit_go) begin
            if (emit_used) begin
              out_valid               <= 1'b1;
              out_data.out_channel_id <= 3'(int'(o_idx));
              out_data.out_sample     <= sat_sample;
              out_data.last_of_frame  <= int'(o_idx) == int'(nout) - 1;
            end
            if (o_idx == OW'(MAX_OUTPUTS - 1)) begin
              state <= S_IDLE;
            end else begin
              o_idx <= o_idx + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        S_SET_RD: state <= S_SET_CHK;
        S_SET_CHK, S_SET_DIV: begin
          if ((state == S_SET_CHK && !div_req.start) ||
              (state == S_SET_DIV && div_rsp.done)) begin
            if (set_last) begin
              state <= S_IDLE;
            end else begin
              cell_addr <= cell_addr + 1'b1;
              state     <= S_SET_RD;
            end
          end else begin
            state <= S_SET_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rmm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Cell memory is only written while a cell is being processed or cleared.
  a_no_cell_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_EMIT_WR || state == S_MIX_ACC) |-> !cell_we)
    else $error("cell memory written outside a cell operation");

  // The divider only answers while a set-gain or clear operation waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_SET_DIV)
    else $error("divider finished outside of a ramp setup");

  // A divide is started only after the cell read and leads to the wait state.
  a_div_start_next: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> state == S_SET_DIV)
    else $error("divider started without waiting for it");

  // A new output item never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_WR && emit_used && out_valid && !out_ready) |=> $stable(out_data))
    else $error("pending output item overwritten");

endmodule

`default_nettype wire

>>> tb/sv/tb_ramped_matrix_mixer.sv
// ============================================================================
// tb_ramped_matrix_mixer
// Self-checking testbench: drives sample, set-gain and clear items with random
// gaps, predicts each mixed output sample and compares it with the block.
// ============================================================================
`default_nettype none

module tb_ramped_matrix_mixer import rmm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NI = 8;
  localparam int NO = 8;
  localparam int NC = NI * NO;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  ramped_matrix_mixer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the mixer state.
  logic [3:0] m_nin, m_nout;
  logic [15:0] m_ramp;
  logic signed [19:0] tgt [NC];
  logic signed [31:0] cur [NC];
  logic signed [31:0] stp [NC];
  logic [15:0] rem [NC];
  logic [47:0] acc [NO];

  out_item_t mixed_q [$];
  int errors = 0;
  int items_sent = 0;
  int frames_seen = 0;
  int results_seen = 0;
  bit no_gaps = 1'b0;

  initial forever #5 clk = ~clk;

  initial begin
    #50ms;
    $display("[ramped_matrix_mixer] ERROR");
    $finish;
  end

  function automatic int used_in();
    if (m_nin < 1) return 1;
    if (m_nin > NI) return NI;
    return m_nin;
  endfunction

  function automatic int used_out();
    if (m_nout < 1) return 1;
    if (m_nout > NO) return NO;
    return m_nout;
  endfunction

  function automatic void load_cell(int c, logic signed [19:0] g);
    logic signed [63:0] diff;
    if (tgt[c] == g) return;
    tgt[c] = g;
    if (m_ramp == 0) begin
      cur[c] = 32'(64'(g) * 256);
      stp[c] = '0;
      rem[c] = '0;
    end else begin
      rem[c] = m_ramp;
      diff = 64'(g) * 256 - 64'(cur[c]);
      stp[c] = 32'(diff / $signed({48'd0, m_ramp}));
    end
  endfunction

  function automatic void mix_item(in_item_t it);
    int nin, nout, c;
    logic signed [63:0] g, p, a;
    out_item_t r;
    nin = used_in();
    nout = used_out();
    if (it.func == FUNC_SET) begin
      if (it.in_channel < nin && it.out_channel < nout)
        load_cell(it.in_channel * NO + it.out_channel, it.gain_value);
      return;
    end
    if (it.func == FUNC_CLEAR) begin
      for (int k = 0; k < NC; k++) load_cell(k, '0);
      return;
    end
    if (it.func != FUNC_SAMPLE || it.in_channel >= nin) return;
    for (int o = 0; o < nout; o++) begin
      c = it.in_channel * NO + o;
      if (rem[c] > 0) begin
        g = 64'(cur[c]);
        cur[c] = cur[c] + stp[c];
        rem[c] = rem[c] - 1;
      end else begin
        cur[c] = 32'(64'(tgt[c]) * 256);
        g = 64'(cur[c]);
      end
      p = 64'(it.in_sample) * g;
      acc[o] = acc[o] + 48'(p >>> 24);
    end
    if (it.in_channel != nin - 1) return;
    for (int o = 0; o < nout; o++) begin
      a = 64'($signed(acc[o]));
      if (a > 64'sd8388607) a = 64'sd8388607;
      if (a < -64'sd8388608) a = -64'sd8388608;
      r.out_channel_id = 3'(o);
      r.out_sample = 24'(a);
      r.last_of_frame = (o == nout - 1);
      mixed_q.push_back(r);
    end
    for (int o = 0; o < NO; o++) acc[o] = '0;
  endfunction

  // Valid stays high across back-to-back items; it drops only before a gap or in drain.
  task automatic send_item(in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mix_item(it);
    items_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_NUM_INPUTS) m_nin = val[3:0];
    else if (idx == CFG_NUM_OUTPUTS) m_nout = val[3:0];
    else if (idx == CFG_RAMP) m_ramp = val;
  endtask

  // Waits out results and any set-gain or clear sweep still in progress.
  task automatic drain();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (mixed_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (2 * NC * (DIV_W + 4) + 100) @(posedge clk);
  endtask

  task automatic configure(int ni, int no, int ramp);
    drain();
    write_reg(CFG_NUM_INPUTS, 16'(ni));
    write_reg(CFG_NUM_OUTPUTS, 16'(no));
    write_reg(CFG_RAMP, 16'(ramp));
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic [1:0] f, int ic, int oc,
                                         logic [23:0] s, logic [19:0] g);
    in_item_t it;
    it.func = f;
    it.in_channel = 3'(ic);
    it.out_channel = 3'(oc);
    it.in_sample = s;
    it.gain_value = g;
    return it;
  endfunction

  task automatic send_frame();
    for (int i = 0; i < used_in(); i++)
      send_item(make_item(FUNC_SAMPLE, i, $urandom, 24'($urandom), 20'($urandom)));
  endtask

  // Checker for every accepted output item.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.last_of_frame) frames_seen++;
        if (mixed_q.size() == 0) begin
          $error("unexpected output item %p", out_data);
          errors++;
        end else begin
          out_item_t e;
          e = mixed_q.pop_front();
          if (out_data.out_channel_id !== e.out_channel_id) begin
            $error("out_channel_id expected %0d actual %0d",
                   e.out_channel_id, out_data.out_channel_id);
            errors++;
          end
          if (out_data.out_sample !== e.out_sample) begin
            $error("out_sample expected %0d actual %0d", e.out_sample, out_data.out_sample);
            errors++;
          end
          if (out_data.last_of_frame !== e.last_of_frame) begin
            $error("last_of_frame expected %0d actual %0d",
                   e.last_of_frame, out_data.last_of_frame);
            errors++;
          end
        end
      end
    end
  end

  // Output stall: a random hold-off drawn per item.
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic test_reset_defaults();
    // One input, one output, default ramp; the zero gains give silence.
    send_item(make_item(FUNC_SAMPLE, 0, 0, 24'h7fffff, '0));
    send_item(make_item(FUNC_SET, 0, 0, '0, 20'h10000));
    send_item(make_item(FUNC_SAMPLE, 0, 0, 24'h400000, '0));
  endtask

  task automatic test_directed();
    configure(2, 3, 0);
    send_item(make_item(FUNC_SET, 0, 0, '0, 20'h7ffff));
    send_item(make_item(FUNC_SET, 1, 0, '0, 20'h7ffff));
    send_item(make_item(FUNC_SET, 0, 1, '0, 20'h80000));
    send_item(make_item(FUNC_SET, 1, 1, '0, 20'h80000));
    send_item(make_item(FUNC_SET, 0, 2, '0, 20'h10000));
    send_item(make_item(FUNC_SET, 0, 2, '0, 20'h10000));      // same target
    send_item(make_item(FUNC_SET, 2, 0, '0, 20'h12345));      // input out of range
    send_item(make_item(FUNC_SET, 0, 5, '0, 20'h12345));      // output out of range
    send_item(make_item(2'd3, 1, 1, 24'h7fffff, 20'h7ffff));  // unused func
    send_item(make_item(FUNC_SAMPLE, 0, 0, 24'h7fffff, '0));
    send_item(make_item(FUNC_SAMPLE, 1, 0, 24'h7fffff, '0));  // saturates
    send_item(make_item(FUNC_SAMPLE, 0, 0, 24'h800000, '0));
    send_item(make_item(FUNC_SAMPLE, 1, 0, 24'h800000, '0));
    send_item(make_item(FUNC_SAMPLE, 5, 0, 24'h123456, '0));  // ignored sample
    configure(2, 3, 3);
    send_item(make_item(FUNC_CLEAR, 0, 0, '0, '0));
    send_frame();
    send_frame();
    send_frame();
    send_frame();
  endtask

  task automatic test_random(int n);
    int r, cnt;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_frame();
        cnt += used_in();
      end else if (r < 90) begin
        send_item(make_item(FUNC_SET, $urandom_range(0, used_in() - 1),
                            $urandom_range(0, used_out() - 1), 24'($urandom),
                            20'($urandom)));
        cnt++;
      end else if (r < 93) begin
        send_item(make_item(FUNC_CLEAR, $urandom, $urandom, 24'($urandom), 20'($urandom)));
        cnt++;
      end else begin
        // Noise: any field values, including unused func and stray channels.
        send_item(make_item(2'($urandom), $urandom, $urandom, 24'($urandom),
                            20'($urandom)));
        cnt++;
      end
    end
  endtask

  task automatic test_sweep();
    configure(8, 8, 16'hffff);
    no_gaps = 1'b1;
    test_random(50);
    no_gaps = 1'b0;
    configure(0, 0, 1);
    test_random(30);
    configure(15, 15, 5);
    test_random(60);
    configure(3, 8, 0);
    test_random(60);
    configure(8, 1, 2);
    test_random(60);
    configure($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
    test_random(120);
  endtask

  initial begin
    m_nin = 1;
    m_nout = 1;
    m_ramp = 480;
    for (int c = 0; c < NC; c++) begin
      tgt[c] = '0; cur[c] = '0; stp[c] = '0; rem[c] = '0;
    end
    for (int o = 0; o < NO; o++) acc[o] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed();
    test_sweep();
    drain();
    if (mixed_q.size() != 0) begin
      $error("%0d output items never arrived", mixed_q.size());
      errors++;
    end
    $display("Sent %0d input items; checked %0d output samples in %0d frames.",
             items_sent, results_seen, frames_seen);
    if (errors == 0) begin
      $display("[ramped_matrix_mixer] OK");
    end else begin
      $display("[ramped_matrix_mixer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> ramped_matrix_mixer.f
design/rmm_pkg.sv
design/rmm_div.sv
design/ramped_matrix_mixer.sv
tb/sv/tb_ramped_matrix_mixer.sv
